>>> sv/autokey_table_stream_descrambler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the autokey table stream descrambler checker.
// ----------------------------------------------------------------------------
`ifndef AUTOKEY_TABLE_STREAM_DESCRAMBLER_ASSERT_SVH
`define AUTOKEY_TABLE_STREAM_DESCRAMBLER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define ATSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ATSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/atsd_pkg.sv
// ----------------------------------------------------------------------------
// atsd_pkg
// Shared types and constants of the autokey table stream descrambler.
// ----------------------------------------------------------------------------
package atsd_pkg;

  // Key whitening pattern applied to a seed word.
  localparam logic [31:0] KeyWhiten  = 32'h5555_5555;
  // Multiplier of the table generator (39916801).
  localparam logic [31:0] GenMult    = 32'd39916801;
  // Mixing table geometry: one entry per byte value.
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAddrW = $clog2(TableDepth);

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_WORD = 2'd1,
    KIND_BYTE = 2'd2,
    KIND_PEEK = 2'd3
  } atsd_kind_e;

  // One access to the mixing table memory.
  typedef struct packed {
    logic                  we;
    logic [TableAddrW-1:0] addr;
    logic [31:0]           wdata;
  } atsd_mem_req_t;

endpackage

>>> sv/autokey_table_stream_descrambler.sv
// ----------------------------------------------------------------------------
// autokey_table_stream_descrambler
// Descrambles a stream of words and bytes with a running key that is updated
// from a 256-entry mixing table built from a seed.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in      | to block  | in_valid_i, in_stall_o | kind_i, raw_data_i
//  out     | from block| out_valid_o, out_stall_i | plain_data_o
//
//  A word item makes four table reads through the single memory port, one per
//  cycle, and then waits for the return of the last read. A byte item makes
//  one table read and a peek item none; a seed writes every table entry.
//  One item is in work at a time, which keeps reads and writes of the table
//  from overlapping. Reset clears the key and control state; the table is
//  not cleared. A finished result waits in the output register while the
//  next item is taken; an item only stalls in its last cycle if that
//  register is still full.
// ----------------------------------------------------------------------------
module autokey_table_stream_descrambler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] raw_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] plain_data_o
);
  import atsd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEED = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   plain_q;
  logic [23:0]   raw_hi_q;
  logic [1:0]    lane_q, lane_d;
  logic          rdv_q, rdv_d;
  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic          in_acc;
  logic          out_load;
  logic          kg_done;
  logic          kg_busy;
  logic [7:0]    look_byte;
  logic [31:0]   rd_data;
  atsd_mem_req_t kg_req, mem_req;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Table generator.
  atsd_keygen u_keygen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (kind_i == KIND_SEED)),
    .seed_i  (raw_data_i ^ KeyWhiten),
    .wr_o    (kg_req),
    .busy_o  (kg_busy),
    .done_o  (kg_done)
  );

  // Byte of the held word that the current lane reads.
  always_comb begin
    unique case (lane_q)
      2'd1:    look_byte = raw_hi_q[7:0];
      2'd2:    look_byte = raw_hi_q[15:8];
      2'd3:    look_byte = raw_hi_q[23:16];
      default: look_byte = raw_hi_q[7:0];
    endcase
  end

  // Memory port: the generator owns it while seeding, lookups otherwise.
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.wdata = '0;
    mem_req.addr  = (state_q == ST_LOOK) ? look_byte : raw_data_i[7:0];
    if (kg_busy) begin
      mem_req = kg_req;
    end
  end

  atsd_table_mem u_table_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_data)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    rdv_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_i)
            KIND_SEED: state_d = ST_SEED;
            KIND_WORD: begin
              state_d = ST_LOOK;
              lane_d  = 2'd1;
              rdv_d   = 1'b1;
            end
            KIND_BYTE: begin
              state_d = ST_DONE;
              rdv_d   = 1'b1;
            end
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SEED: begin
        if (kg_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOK: begin
        rdv_d  = 1'b1;
        lane_d = lane_q + 2'd1;
        if (lane_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Running key: a seed replaces it, each returned table word is folded in.
  always_comb begin
    key_d = key_q;
    if (in_acc && (kind_i == KIND_SEED)) begin
      key_d = raw_data_i ^ KeyWhiten;
    end else if (rdv_q) begin
      key_d = key_q ^ rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_q      <= '0;
      rdv_q       <= 1'b0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      rdv_q   <= rdv_d;
      key_q   <= key_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload: the result is formed from the key as it stood on entry.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_hi_q <= raw_data_i[31:8];
      if (kind_i == KIND_BYTE) begin
        plain_q <= {24'd0, raw_data_i[7:0] ^ key_q[7:0]};
      end else begin
        plain_q <= raw_data_i ^ key_q;
      end
    end
    if (out_load) begin
      out_data_q <= plain_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_data_o = out_data_q;

endmodule

>>> sv/atsd_table_mem.sv
// ----------------------------------------------------------------------------
// atsd_table_mem
// Single-port mixing table memory with a registered read.
// ----------------------------------------------------------------------------
module atsd_table_mem (
  input  logic                   clk_i,
  input  atsd_pkg::atsd_mem_req_t req_i,
  output logic [31:0]            rdata_o
);
  import atsd_pkg::*;

  logic [31:0] mem [TableDepth];
  logic [31:0] rdata_q;

  // Write when requested; the read data is registered every cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/atsd_keygen.sv
// ----------------------------------------------------------------------------
// atsd_keygen
// Table generator: one rotate and multiply step per cycle, each step writing
// one entry of the mixing table.
// ----------------------------------------------------------------------------
module atsd_keygen (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [31:0]             seed_i,
  output atsd_pkg::atsd_mem_req_t wr_o,
  output logic                    busy_o,
  output logic                    done_o
);
  import atsd_pkg::*;

  logic [31:0]           gen_q, gen_d;
  logic [TableAddrW-1:0] idx_q;
  logic                  busy_q;
  logic [31:0]           rot;
  logic                  last;

  // Rotate right by one, then multiply modulo 2^32.
  assign rot   = {gen_q[0], gen_q[31:1]};
  assign gen_d = rot * GenMult;
  assign last  = busy_q && (idx_q == TableAddrW'(TableDepth - 1));

  // Sweep through every table entry once per seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= '0;
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      gen_q  <= seed_i;
      idx_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      gen_q  <= gen_d;
      idx_q  <= idx_q + 1'b1;
      busy_q <= !last;
    end
  end

  assign wr_o.we    = busy_q;
  assign wr_o.addr  = idx_q;
  assign wr_o.wdata = gen_d;
  assign busy_o     = busy_q;
  assign done_o     = last;

endmodule

>>> sv/atsd_checker.sv
// ----------------------------------------------------------------------------
// atsd_checker
// Port-level checks of the autokey table stream descrambler, bound to it.
// ----------------------------------------------------------------------------
`include "autokey_table_stream_descrambler_assert.svh"

module atsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  kind_i,
  input logic [31:0] raw_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] plain_data_o
);
  import atsd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result holds.
  `ATSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(plain_data_o), "stalled result changed")

  // Items are worked one at a time.
  `ATSD_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_acc, in_stall_o, "item taken while another is in work")

  // A seed gives no result.
  `ATSD_ASSERT_NEXT(a_seed_silent, clk_i, rst_ni, in_acc && (kind_i == KIND_SEED), !$rose(out_valid_o), "seed produced a result")

  // A byte result arrives with its upper bits clear.
  `ATSD_ASSERT_NEXT(a_byte_result, clk_i, rst_ni, in_acc && (kind_i == KIND_BYTE) && !out_valid_o, ##1 (out_valid_o && (plain_data_o[31:8] == 24'd0)), "byte result late or wide")

  // An accepted item carries no unknown bits.
  `ATSD_ASSERT_NOW(a_in_known, clk_i, rst_ni, in_acc, !$isunknown(kind_i) && !$isunknown(raw_data_i), "input item unknown")

endmodule

bind autokey_table_stream_descrambler atsd_checker u_atsd_checker (.*);

>>> sim/tb_autokey_table_stream_descrambler.sv
// ----------------------------------------------------------------------------
// tb_autokey_table_stream_descrambler
// Self-checking bench for the autokey table stream descrambler. A queue of
// seed, word, byte and peek items is driven through the input channel with
// random gaps. Every accepted item is run through a local copy of the key
// and mixing table to predict the plain data. Each result taken from the
// output channel, which sees random stalls, is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_autokey_table_stream_descrambler;
  timeunit 1ns;
  timeprecision 1ps;

  import atsd_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 400;
  localparam int unsigned RandomItems   = 1250;

  typedef struct {
    atsd_kind_e  kind;
    logic [31:0] raw;
    bit          drain;  // Hold this item back until every result is out.
  } scramble_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind_drv = KIND_PEEK;
  logic [31:0] raw_drv = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] plain_data;

  scramble_item_t pending_items[$];
  logic [31:0]    plain_expected[$];

  // Local copy of the descrambler state.
  logic [31:0] model_key;
  logic [31:0] mix_tab [TableDepth];

  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cyc_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_total = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatch_cnt = 0;
  logic        calm;

  autokey_table_stream_descrambler i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind_drv),
    .raw_data_i   (raw_drv),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .plain_data_o (plain_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // While bits 9:8 of the cycle count are zero, no new gaps or stalls are started.
  assign calm = (cyc_cnt[9:8] == 2'b00);

  // Works out the plain data of one item and updates the local key and table.
  function automatic bit predict_plain(input atsd_kind_e kind, input logic [31:0] raw,
                                       output logic [31:0] plain);
    logic [31:0] g;
    int          i;
    plain = '0;
    predict_plain = 1'b1;
    case (kind)
      KIND_SEED: begin
        g = raw ^ KeyWhiten;
        model_key = g;
        for (i = 0; i < TableDepth; i++) begin
          g = {g[0], g[31:1]};
          g = g * GenMult;
          mix_tab[i] = g;
        end
        predict_plain = 1'b0;
      end
      KIND_WORD: begin
        plain = raw ^ model_key;
        model_key = model_key ^ mix_tab[raw[7:0]] ^ mix_tab[raw[15:8]]
                    ^ mix_tab[raw[23:16]] ^ mix_tab[raw[31:24]];
      end
      KIND_BYTE: begin
        plain = {24'h0, raw[7:0] ^ model_key[7:0]};
        model_key = model_key ^ mix_tab[raw[7:0]];
      end
      default: begin
        plain = raw ^ model_key;
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 15);
    else return $urandom_range(30, 90);
  endfunction

  // Raw words with a bias towards the extremes and to single-byte patterns.
  function automatic logic [31:0] pick_raw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0000_0000;
    else if (r < 16) return 32'hFFFF_FFFF;
    else if (r < 26) return {4{8'($urandom_range(0, 255))}};
    else return $urandom;
  endfunction

  task automatic push_item(input atsd_kind_e kind, input logic [31:0] raw,
                           input bit drain = 1'b0);
    scramble_item_t it;
    it.kind  = kind;
    it.raw   = raw;
    it.drain = drain;
    pending_items.push_back(it);
    items_total++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, exp_val, act_val);
    end
  endtask

  // Input driver: loads the next item once the current one has been taken.
  always @(negedge clk_i) begin
    scramble_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain && plain_expected.size() != 0)) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        kind_drv <= nxt.kind;
        raw_drv  <= nxt.raw;
        gap_left <= calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall driver.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Monitor: checks results, predicts accepted items and guards against hangs.
  always @(posedge clk_i) begin
    logic [31:0] exp_plain;
    if (rst_ni) begin
      cyc_cnt <= cyc_cnt + 1;
      if (out_valid && !out_stall) begin
        if (plain_expected.size() == 0) begin
          report_mismatch("result with no item waiting", '0, plain_data);
        end else begin
          exp_plain = plain_expected.pop_front();
          if (plain_data !== exp_plain) begin
            report_mismatch("plain_data mismatch", exp_plain, plain_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_plain(atsd_kind_e'(kind_drv), raw_drv, exp_plain)) begin
          plain_expected.push_back(exp_plain);
        end
        items_accepted++;
      end
      in_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned r;
    atsd_kind_e  k;

    // Peeks before any seed: the key is still zero.
    push_item(KIND_PEEK, 32'h0000_0000);
    push_item(KIND_PEEK, 32'hFFFF_FFFF);
    // This seed whitens to zero, so every table entry is zero.
    push_item(KIND_SEED, 32'h5555_5555);
    push_item(KIND_WORD, 32'hFFFF_FFFF);
    push_item(KIND_BYTE, 32'h1234_56A5);
    push_item(KIND_PEEK, 32'hA5A5_A5A5, 1'b1);
    // This seed gives an all-ones key.
    push_item(KIND_SEED, 32'hAAAA_AAAA);
    push_item(KIND_PEEK, 32'h0000_0000);
    push_item(KIND_WORD, 32'h0000_0000);
    push_item(KIND_WORD, 32'hFFFF_FFFF);
    push_item(KIND_BYTE, 32'hFFFF_FF00);
    push_item(KIND_BYTE, 32'h0000_00FF);
    push_item(KIND_BYTE, 32'hFFFF_FFFF);
    push_item(KIND_WORD, 32'h0302_0100);
    push_item(KIND_PEEK, 32'hFFFF_FFFF);
    // Back-to-back seeds: the second one replaces table and key.
    push_item(KIND_SEED, 32'h0000_0000);
    push_item(KIND_SEED, 32'hFFFF_FFFF);
    push_item(KIND_WORD, 32'h8040_2010);
    push_item(KIND_BYTE, 32'h0000_0080);
    push_item(KIND_PEEK, 32'h1357_9BDF, 1'b1);
    push_item(KIND_WORD, 32'hFEDC_BA98);
    push_item(KIND_SEED, $urandom);
    push_item(KIND_WORD, $urandom);

    // Random traffic; a seed has already been given, so any kind is legal.
    repeat (RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 3) k = KIND_SEED;
      else if (r < 43) k = KIND_WORD;
      else if (r < 73) k = KIND_BYTE;
      else k = KIND_PEEK;
      push_item(k, pick_raw(), ($urandom_range(0, 99) == 0));
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (items_accepted == items_total);
    wait (plain_expected.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && plain_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/atsd_pkg.sv
sv/atsd_table_mem.sv
sv/atsd_keygen.sv
sv/autokey_table_stream_descrambler.sv
sv/atsd_checker.sv
sim/tb_autokey_table_stream_descrambler.sv
